// ===== hdl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants and types of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int RADIX_W = 16;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 16'd2;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 16'd2;

   // Status of the item queue as seen by the back end.
   typedef struct packed {
      logic head_valid;
      logic full;
   } queue_status_type;

endpackage

// ===== hdl/rdc_front.sv =====
// ----------------------------------------------------------------------------
// rdc_front
// Accepts values, settles the base that applies and queues both for the
// conversion engine in a two-entry queue.
// ----------------------------------------------------------------------------
module rdc_front
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [RADIX_W-1:0]     radix,
   input  logic                   pop,
   output queue_status_type       status,
   output logic [VALUE_WIDTH-1:0] head_value,
   output logic [RADIX_W-1:0]     head_base
);

   logic [VALUE_WIDTH-1:0] value_ff [2];
   logic [RADIX_W-1:0]     base_ff  [2];
   logic [1:0]             count_ff, count_in;
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic                   push;
   logic [RADIX_W-1:0]     base_sel;

   // A base of zero or one converts as base two.
   assign base_sel = (radix < RADIX_MIN) ? RADIX_MIN : radix;

   assign req_ready         = (count_ff != 2'd2);
   assign push              = req_valid && req_ready;
   assign status.head_valid = (count_ff != 2'd0);
   assign status.full       = (count_ff == 2'd2);
   assign head_value        = value_ff[rd_ptr_ff];
   assign head_base         = base_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         value_ff[wr_ptr_ff] <= req_value;
         base_ff[wr_ptr_ff]  <= base_sel;
      end
   end

endmodule

// ===== hdl/rdc_divider.sv =====
// ----------------------------------------------------------------------------
// rdc_divider
// Restoring bit-serial divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdc_divider
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [RADIX_W-1:0]     divisor,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [RADIX_W-1:0]     remainder
);

   localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   logic [VALUE_WIDTH-1:0] q_ff;
   logic [RADIX_W-1:0]     d_ff;
   logic [RADIX_W-1:0]     rem_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [RADIX_W:0]       rem_shift;
   logic                   fits;
   logic [RADIX_W-1:0]     rem_in;
   logic [VALUE_WIDTH-1:0] q_in;

   always_comb begin
      rem_shift = {rem_ff, q_ff[VALUE_WIDTH-1]};
      fits      = (rem_shift >= {1'b0, d_ff});
      rem_in    = fits ? RADIX_W'(rem_shift - {1'b0, d_ff}) : RADIX_W'(rem_shift);
      q_in      = {q_ff[VALUE_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         d_ff   <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/rdc_back.sv =====
// ----------------------------------------------------------------------------
// rdc_back
// Conversion engine: divides by the base, stacks the remainders and pops the
// stack into the result register, most significant digit first.
// ----------------------------------------------------------------------------
module rdc_back
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_DIGITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  queue_status_type       status,
   input  logic [VALUE_WIDTH-1:0] head_value,
   input  logic [RADIX_W-1:0]     head_base,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [RADIX_W-1:0]     rsp_digit,
   output logic                   rsp_last_digit
);

   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int CMP_W = (VALUE_WIDTH > RADIX_W) ? VALUE_WIDTH : RADIX_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV_WAIT,
      S_READ,
      S_OUT
   } state_type;

   state_type              state_ff;
   logic [VALUE_WIDTH-1:0] quot_ff;
   logic [RADIX_W-1:0]     base_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   last_ff;
   logic                   rsp_valid_ff;
   logic [RADIX_W-1:0]     rsp_digit_ff;
   logic                   rsp_last_ff;
   logic [RADIX_W-1:0]     digit_stack_ff [MAX_DIGITS];
   logic [RADIX_W-1:0]     rd_data_ff;

   logic                   div_start;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quot;
   logic [RADIX_W-1:0]     div_rem;
   logic                   more_digits;
   logic                   room;
   logic                   wr_en;
   logic [RADIX_W-1:0]     wr_data;
   logic                   rd_en;
   logic [CNT_W-1:0]       count_dec;
   logic                   out_free;

   assign more_digits = (CMP_W'(quot_ff) >= CMP_W'(base_ff));
   assign room        = (count_ff < CNT_W'(MAX_DIGITS));
   assign pop         = (state_ff == S_IDLE) && status.head_valid;
   assign div_start   = (state_ff == S_CHECK) && more_digits;
   assign count_dec   = count_ff - 1'b1;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rd_en       = (state_ff == S_READ);

   // Digits past the stack depth are dropped; the low-order ones are kept.
   always_comb begin
      wr_en   = 1'b0;
      wr_data = div_rem;
      if (state_ff == S_CHECK && !more_digits) begin
         wr_en   = room;
         wr_data = RADIX_W'(quot_ff);
      end else if (state_ff == S_DIV_WAIT && div_done) begin
         wr_en   = room;
         wr_data = div_rem;
      end
   end

   rdc_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (quot_ff),
      .divisor  (base_ff),
      .done     (div_done),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_digit_ff <= '0;
         rsp_last_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (status.head_valid) begin
                  count_ff <= '0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (more_digits) begin
                  state_ff <= S_DIV_WAIT;
               end else begin
                  if (room) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  state_ff <= S_READ;
               end
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  if (room) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  state_ff <= S_CHECK;
               end
            end
            S_READ: begin
               count_ff <= count_dec;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_digit_ff <= rd_data_ff;
                  rsp_last_ff  <= last_ff;
                  state_ff     <= last_ff ? S_IDLE : S_READ;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         quot_ff <= head_value;
         base_ff <= head_base;
      end else if (state_ff == S_DIV_WAIT && div_done) begin
         quot_ff <= div_quot;
      end
      if (state_ff == S_READ) begin
         last_ff <= (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_stack_ff[count_ff[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= digit_stack_ff[count_dec[IDX_W-1:0]];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit      = rsp_digit_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule

// ===== hdl/radix_digit_converter_core.sv =====
// The engine converts one value at a time: it divides by the base in the
// bit-serial divider until the quotient is below the base, then presents
// the stacked digits; a two-entry queue takes further values while the
// engine converts.
// Reset is synchronous: it empties the queue, idles the engine and sets the
// radix to two. The digit stack is not cleared.
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts unsigned values into digits of a programmable base.
// ----------------------------------------------------------------------------
module radix_digit_converter_core
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_DIGITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [RADIX_W-1:0]     rsp_digit,
   output logic                   rsp_last_digit,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [RADIX_W-1:0]     csr_radix
);

   logic [RADIX_W-1:0]     radix_ff;
   queue_status_type       status;
   logic [VALUE_WIDTH-1:0] head_value;
   logic [RADIX_W-1:0]     head_base;
   logic                   pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid && csr_ready) begin
         radix_ff <= csr_radix;
      end
   end

   rdc_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .radix     (radix_ff),
      .pop       (pop),
      .status    (status),
      .head_value(head_value),
      .head_base (head_base)
   );

   rdc_back #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .status        (status),
      .head_value    (head_value),
      .head_base     (head_base),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_digit     (rsp_digit),
      .rsp_last_digit(rsp_last_digit)
   );

   // The engine only takes a transaction that the queue holds.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> status.head_valid)
      else $error("engine popped an empty queue");

   // The queue fills only through an accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("request ready dropped without a transaction");

   // A full queue never reports an empty head.
   assert property (@(posedge clock) disable iff (reset)
      status.full |-> status.head_valid)
      else $error("queue status inconsistent");

endmodule
